/* hw/rtl/link_frame_fletcher_encoder_core_macros.svh */
// -----------------------------------------------------------------------------
// Link frame encoder assertion macros
// Shared macros for concurrent assertions clocked on clk.
// -----------------------------------------------------------------------------
`ifndef LINK_FRAME_FLETCHER_ENCODER_CORE_MACROS_SVH
`define LINK_FRAME_FLETCHER_ENCODER_CORE_MACROS_SVH

// Checked only while the block is out of reset.
`define LFFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LFFE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/lffe_pkg.sv */
// -----------------------------------------------------------------------------
// Link frame encoder package
// Constants and types shared by the frame encoder modules.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lffe_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;
  localparam logic [7:0]  START_FIRST     = 8'hBC;
  localparam logic [7:0]  START_SECOND    = 8'hCF;
  localparam int unsigned BUNDLE_MAX      = 6;
  localparam int unsigned CNT_W           = $clog2(BUNDLE_MAX + 1);
  localparam int unsigned IDX_W           = $clog2(BUNDLE_MAX);

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_DATA   = 1'b1
  } lffe_kind_t;

  // All result bytes caused by one input item, in output order.
  typedef struct packed {
    logic [BUNDLE_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]           cnt;
    logic                       has_end;
    logic                       err;
  } lffe_bundle_t;

endpackage

/* hw/rtl/lffe_if.sv */
// -----------------------------------------------------------------------------
// Link frame encoder channels
// Valid/ready channels for input items and serialized frame bytes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lffe_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] pkt_type;
  logic [7:0] pkt_length;
  logic [7:0] data_byte;

  modport source (output valid, kind, pkt_type, pkt_length, data_byte, input ready);
  modport sink   (input valid, kind, pkt_type, pkt_length, data_byte, output ready);
endinterface

interface lffe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       error;

  modport source (output valid, out_byte, frame_end, error, input ready);
  modport sink   (input valid, out_byte, frame_end, error, output ready);
endinterface

/* hw/rtl/lffe_core.sv */
// -----------------------------------------------------------------------------
// Link frame encoder item stage
// Updates frame state and checksums per item and registers its result bytes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lffe_core #(
  parameter int unsigned MAX_PAYLOAD = lffe_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lffe_in_if.sink               in_chan,
  output lffe_pkg::lffe_bundle_t bun,
  output logic                  bun_valid,
  input  logic                  bun_take
);
  import lffe_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic         frame_open_r, frame_open_nxt;
  logic [7:0]   bytes_left_r, bytes_left_nxt;
  logic [7:0]   sum_first_r, sum_first_nxt;
  logic [7:0]   sum_second_r, sum_second_nxt;
  lffe_bundle_t bun_r, bun_nxt;
  logic         bun_valid_r;
  logic         accept;

  assign in_chan.ready = !bun_valid_r || bun_take;
  assign accept        = in_chan.valid && in_chan.ready;
  assign bun           = bun_r;
  assign bun_valid     = bun_valid_r;

  always_comb begin
    bun_nxt        = '0;
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    sum_first_nxt  = sum_first_r;
    sum_second_nxt = sum_second_r;
    if (in_chan.kind == KIND_HEADER) begin
      if (in_chan.pkt_length > MAX_LEN) begin
        bun_nxt.cnt = CNT_W'(1);
        bun_nxt.err = 1'b1;
      end else begin
        // Seeding with type then length: first = type + len, second = type + first.
        sum_first_nxt    = in_chan.pkt_type + in_chan.pkt_length;
        sum_second_nxt   = in_chan.pkt_type + sum_first_nxt;
        bun_nxt.bytes[0] = START_FIRST;
        bun_nxt.bytes[1] = START_SECOND;
        bun_nxt.bytes[2] = in_chan.pkt_type;
        bun_nxt.bytes[3] = in_chan.pkt_length;
        if (in_chan.pkt_length == 8'd0) begin
          bun_nxt.bytes[4] = sum_first_nxt;
          bun_nxt.bytes[5] = sum_second_nxt;
          bun_nxt.cnt      = CNT_W'(6);
          bun_nxt.has_end  = 1'b1;
          frame_open_nxt   = 1'b0;
          bytes_left_nxt   = 8'd0;
        end else begin
          bun_nxt.cnt    = CNT_W'(4);
          frame_open_nxt = 1'b1;
          bytes_left_nxt = in_chan.pkt_length;
        end
      end
    end else if (!frame_open_r) begin
      bun_nxt.cnt = CNT_W'(1);
      bun_nxt.err = 1'b1;
    end else begin
      sum_first_nxt    = sum_first_r + in_chan.data_byte;
      sum_second_nxt   = sum_second_r + sum_first_nxt;
      bytes_left_nxt   = bytes_left_r - 8'd1;
      bun_nxt.bytes[0] = in_chan.data_byte;
      if (bytes_left_nxt == 8'd0) begin
        bun_nxt.bytes[1] = sum_first_nxt;
        bun_nxt.bytes[2] = sum_second_nxt;
        bun_nxt.cnt      = CNT_W'(3);
        bun_nxt.has_end  = 1'b1;
        frame_open_nxt   = 1'b0;
      end else begin
        bun_nxt.cnt = CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= 8'd0;
      sum_first_r  <= 8'd0;
      sum_second_r <= 8'd0;
      bun_valid_r  <= 1'b0;
    end else if (accept) begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
      sum_first_r  <= sum_first_nxt;
      sum_second_r <= sum_second_nxt;
      bun_valid_r  <= 1'b1;
    end else if (bun_take) begin
      bun_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bun_r <= bun_nxt;
    end
  end

endmodule

/* hw/rtl/lffe_ser.sv */
// -----------------------------------------------------------------------------
// Link frame encoder serializer
// Emits the result bytes of one item, one byte per output transfer.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lffe_ser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lffe_pkg::lffe_bundle_t bun,
  input  logic                   bun_valid,
  output logic                   bun_take,
  lffe_out_if.source             out_chan
);
  import lffe_pkg::*;

  lffe_bundle_t     hold_r;
  logic             hold_valid_r;
  logic [IDX_W-1:0] idx_r;
  logic             last;
  logic             xfer;

  assign last     = (CNT_W'(idx_r) == CNT_W'(hold_r.cnt - CNT_W'(1)));
  assign xfer     = hold_valid_r && out_chan.ready;
  assign bun_take = !hold_valid_r || (xfer && last);

  assign out_chan.valid     = hold_valid_r;
  assign out_chan.out_byte  = hold_r.bytes[idx_r];
  assign out_chan.frame_end = hold_r.has_end && last;
  assign out_chan.error     = hold_r.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      idx_r        <= '0;
    end else if (bun_take) begin
      hold_valid_r <= bun_valid;
      idx_r        <= '0;
    end else if (xfer) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (bun_take) begin
      hold_r <= bun;
    end
  end

endmodule

/* hw/rtl/link_frame_fletcher_encoder_core.sv */
// -----------------------------------------------------------------------------
// Link frame encoder
// Serializes link frames with start bytes, type, length, payload and a
// Fletcher-8 checksum pair.
// -----------------------------------------------------------------------------
// Channel   Dir  Payload                                  Transfer per
// in_chan   in   kind, pkt_type, pkt_length, data_byte    input item
// out_chan  out  out_byte, frame_end, error               frame byte
//
// An item is registered in the core, then copied to the serializer's hold
// register, from which its first byte is offered; its bytes leave one per cycle
// while out_chan is ready: 1 for a payload byte or a rejected item, 3 for the
// last payload byte, 4 for a header, 6 for a header of length zero.
// The serializer sets the rate: a new item enters as the previous item's last
// byte transfers, so payload bytes stream one per cycle while out_chan is ready.
// Reset clears frame state and empties both stages; no clearing pass.
// A stall on out_chan holds the current byte; in_chan stalls once one item
// waits behind the one being serialized.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_frame_fletcher_encoder_core #(
  parameter int unsigned MAX_PAYLOAD = lffe_pkg::MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lffe_in_if.sink    in_chan,
  lffe_out_if.source out_chan
);
  import lffe_pkg::*;

  lffe_bundle_t bun;
  logic         bun_valid;
  logic         bun_take;

  lffe_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .bun      (bun),
    .bun_valid(bun_valid),
    .bun_take (bun_take)
  );

  lffe_ser u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .bun      (bun),
    .bun_valid(bun_valid),
    .bun_take (bun_take),
    .out_chan (out_chan)
  );

endmodule

/* hw/rtl/lffe_chk.sv */
// -----------------------------------------------------------------------------
// Link frame encoder checker
// Port-level assertions, bound to the encoder top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "link_frame_fletcher_encoder_core_macros.svh"

module lffe_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       frame_end,
  input logic       error
);

  // Input back-pressure only happens while a byte is waiting on the output.
  `LFFE_ASSERT(a_stall_has_output, (!in_ready |-> out_valid), "input stalled with no output pending")

  // An item accepted into an empty block shows a byte after passing the core and serializer registers.
  `LFFE_ASSERT(a_item_reaches_output, (in_valid && in_ready && !out_valid |=> ##1 out_valid), "accepted item produced no output")

  // A rejected item and a frame end never coincide, and rejects carry a zero byte.
  `LFFE_ASSERT(a_error_form, (out_valid && error |-> !frame_end && out_byte == 8'd0), "malformed error result")

  // Coming out of reset both stages are empty.
  `LFFE_ASSERT_RST(a_reset_empty, (!rst_n |=> !out_valid && in_ready), "block not empty after reset")

endmodule

bind link_frame_fletcher_encoder_core lffe_chk u_lffe_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_chan.valid),
  .in_ready (in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_byte (out_chan.out_byte),
  .frame_end(out_chan.frame_end),
  .error    (out_chan.error)
);
